### rtl/dqpr_pkg.sv
`default_nettype none
package dqpr_pkg;

   localparam int unsigned DQPR_CAPACITY = 16;
   localparam int unsigned DQPR_ID_WIDTH = 8;

   localparam int unsigned OP_W  = 3;
   localparam int unsigned VAL_W = 8;
   localparam int unsigned POS_W = 5;
   localparam int unsigned ST_W  = 2;
   localparam int unsigned OCC_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REMOVE     = 3'd4
   } dqpr_op_type;

   typedef enum logic [ST_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } dqpr_status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_FETCH,
      SEQ_SHIFT,
      SEQ_DONE
   } dqpr_state_type;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] position;
   } dqpr_req_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [VAL_W-1:0] removed_value;
      logic [OCC_W-1:0] occupancy;
   } dqpr_rsp_type;

endpackage
`default_nettype wire

### rtl/dqpr_ram.sv
`default_nettype none
module dqpr_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/dqpr_slot_unit.sv
`default_nettype none
module dqpr_slot_unit #(
   parameter int unsigned CAPACITY = 16,
   parameter int unsigned IDX_W    = $clog2(CAPACITY)
) (
   input  logic [IDX_W-1:0] base,
   input  logic [IDX_W-1:0] offset,
   output logic [IDX_W-1:0] slot
);

   localparam int unsigned SUM_W = IDX_W + 1;
   localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);

   logic [SUM_W-1:0] sum;

   // Both operands are below the capacity, so one conditional subtract wraps the sum.
   always_comb begin
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= CAP_SUM) begin
         slot = IDX_W'(sum - CAP_SUM);
      end else begin
         slot = IDX_W'(sum);
      end
   end

endmodule
`default_nettype wire

### rtl/deque_with_positional_removal.sv
// Pushes, rejected operations and unused codes go from acceptance straight to the
// result; pops first read the entry from the store, and a positional removal then
// moves each later entry through the single RAM read port and the shared slot
// adder, one entry per cycle.
// One item is in work at a time; the next is taken once the result is registered.
// Synchronous reset empties the queue and clears the front index; store contents stay.
`default_nettype none
module deque_with_positional_removal #(
   parameter int unsigned CAPACITY = dqpr_pkg::DQPR_CAPACITY,
   parameter int unsigned ID_WIDTH = dqpr_pkg::DQPR_ID_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dqpr_pkg::dqpr_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dqpr_pkg::dqpr_rsp_type rsp_data
);
   import dqpr_pkg::*;

   localparam int unsigned IDX_W   = $clog2(CAPACITY);
   localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
   localparam int unsigned STORE_W = (ID_WIDTH < VAL_W) ? ID_WIDTH : VAL_W;
   localparam int unsigned CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_OFS = IDX_W'(CAPACITY - 1);

   dqpr_state_type     state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   front_ff, front_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   raddr_ff, raddr_in;
   logic [IDX_W-1:0]   wr_addr_ff, wr_addr_in;
   dqpr_rsp_type       res_ff, res_in;
   dqpr_rsp_type       rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic               full;
   logic               empty;
   logic               more;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   cnt_ext;
   logic [IDX_W-1:0]   k_ofs;
   logic [IDX_W-1:0]   ofs;
   logic [IDX_W-1:0]   slot;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [STORE_W-1:0] ram_wdata;
   logic [STORE_W-1:0] ram_rdata;

   dqpr_slot_unit #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_slot (
      .base   (front_ff),
      .offset (ofs),
      .slot   (slot)
   );

   dqpr_ram #(
      .WIDTH  (STORE_W),
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (slot),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != SEQ_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (cnt_ff == CAP_CNT);
   assign empty     = (cnt_ff == '0);
   assign more      = (CNT_W'(idx_ff) + CNT_W'(1)) < cnt_ff;
   assign pos_ext   = CMP_W'(req_data.position);
   assign cnt_ext   = CMP_W'(cnt_ff);

   // Position zero means the front; positions past the end mean the last entry.
   always_comb begin
      if (pos_ext == '0) begin
         k_ofs = '0;
      end else if (pos_ext > cnt_ext) begin
         k_ofs = IDX_W'(cnt_ff - CNT_W'(1));
      end else begin
         k_ofs = IDX_W'(pos_ext - CMP_W'(1));
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               if ((req_data.operation inside {OP_POP_FRONT, OP_POP_BACK, OP_REMOVE})
                   && !empty) begin
                  state_in = SEQ_FETCH;
               end else begin
                  state_in = SEQ_DONE;
               end
            end
         end
         SEQ_FETCH: begin
            if ((op_ff == OP_REMOVE) && more) begin
               state_in = SEQ_SHIFT;
            end else begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_SHIFT: begin
            if (!more) begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      front_in     = front_ff;
      idx_in       = idx_ff;
      raddr_in     = raddr_ff;
      wr_addr_in   = wr_addr_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ofs          = '0;
      ram_we       = 1'b0;
      ram_waddr    = slot;
      ram_wdata    = STORE_W'(req_data.value);

      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               op_in                = req_data.operation;
               res_in.status        = STAT_OK;
               res_in.removed_value = '0;
               res_in.occupancy     = OCC_W'(cnt_ff);
               case (req_data.operation) inside
                  OP_PUSH_BACK: begin
                     if (full) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        ofs              = IDX_W'(cnt_ff);
                        ram_we           = 1'b1;
                        cnt_in           = cnt_ff + CNT_W'(1);
                        res_in.occupancy = OCC_W'(cnt_ff + CNT_W'(1));
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        ofs              = LAST_OFS;
                        ram_we           = 1'b1;
                        front_in         = slot;
                        cnt_in           = cnt_ff + CNT_W'(1);
                        res_in.occupancy = OCC_W'(cnt_ff + CNT_W'(1));
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: begin
                     if (empty) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        if (req_data.operation == OP_POP_FRONT) begin
                           ofs = '0;
                        end else if (req_data.operation == OP_POP_BACK) begin
                           ofs = IDX_W'(cnt_ff - CNT_W'(1));
                        end else begin
                           ofs = k_ofs;
                        end
                        raddr_in = slot;
                        idx_in   = ofs;
                     end
                  end
                  default: ;
               endcase
            end
         end
         SEQ_FETCH: begin
            res_in.status        = STAT_OK;
            res_in.removed_value = VAL_W'(ram_rdata);
            res_in.occupancy     = OCC_W'(cnt_ff - CNT_W'(1));
            if (op_ff == OP_POP_FRONT) begin
               ofs      = IDX_W'(1);
               front_in = slot;
               cnt_in   = cnt_ff - CNT_W'(1);
            end else if ((op_ff == OP_REMOVE) && more) begin
               ofs        = idx_ff + IDX_W'(1);
               raddr_in   = slot;
               wr_addr_in = raddr_ff;
               idx_in     = idx_ff + IDX_W'(1);
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         SEQ_SHIFT: begin
            // The entry read last cycle moves one place toward the front.
            ram_we    = 1'b1;
            ram_waddr = wr_addr_ff;
            ram_wdata = ram_rdata;
            if (more) begin
               ofs        = idx_ff + IDX_W'(1);
               raddr_in   = slot;
               wr_addr_in = raddr_ff;
               idx_in     = idx_ff + IDX_W'(1);
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         SEQ_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         cnt_ff       <= '0;
         front_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         front_ff     <= front_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      raddr_ff   <= raddr_in;
      wr_addr_ff <= wr_addr_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CAP_CNT)
      else $error("entry count exceeds capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && !full && ((req_data.operation == OP_PUSH_BACK) ||
                           (req_data.operation == OP_PUSH_FRONT)))
      |=> (cnt_ff == CNT_W'($past(cnt_ff) + CNT_W'(1))))
      else $error("accepted push did not grow the queue");

   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SHIFT) |-> (wr_addr_ff != raddr_ff))
      else $error("shift writes the slot it is reading");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_DONE) && rsp_valid_ff && rsp_stall |=> (state_ff == SEQ_DONE))
      else $error("result dropped while output register was occupied");

endmodule
`default_nettype wire
